// ----- design/cse_pkg.sv -----
package cse_pkg;

    typedef enum logic [1:0] {
        OP_UINT  = 2'd0,
        OP_SINT  = 2'd1,
        OP_FLOAT = 2'd2,
        OP_BOOL  = 2'd3
    } t_op;

    localparam logic [2:0] MT_UINT = 3'd0;
    localparam logic [2:0] MT_NINT = 3'd1;

    localparam logic [4:0] AI_1BYTE = 5'd24;
    localparam logic [4:0] AI_2BYTE = 5'd25;
    localparam logic [4:0] AI_4BYTE = 5'd26;
    localparam logic [4:0] AI_8BYTE = 5'd27;

    localparam logic [7:0] HEAD_FLOAT32 = 8'hFA;
    localparam logic [7:0] HEAD_FALSE   = 8'hF4;
    localparam logic [7:0] HEAD_TRUE    = 8'hF5;

    localparam logic [3:0] FLOAT_LEN = 4'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value_bits;
        logic [3:0]  space_left;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out;

    // classified item: head byte plus left-aligned argument bytes
    typedef struct packed {
        logic [7:0]  head;
        logic [63:0] arg;
        logic [3:0]  nfollow;
        logic        err;
    } t_cmd;

endpackage

// ----- design/cse_front.sv -----
module cse_front #(
    parameter int INT64_SUPPORT = 1
) (
    input  cse_pkg::t_in  i_item,
    output cse_pkg::t_cmd o_cmd
);
    import cse_pkg::*;

    logic [63:0] v;
    logic [63:0] arg;
    logic [2:0]  major;
    logic [4:0]  info;
    logic [3:0]  nfollow;
    logic        wide;
    logic        range_err;
    logic        err;
    logic [7:0]  head;
    logic [63:0] aligned;
    logic [3:0]  space;

    always_comb begin
        v         = i_item.value_bits;
        space     = i_item.space_left;
        major     = MT_UINT;
        arg       = v;
        range_err = 1'b0;
        if (i_item.operation == OP_SINT && v[63]) begin
            major = MT_NINT;
            arg   = ~v;
        end
        if (INT64_SUPPORT == 0 && i_item.operation == OP_SINT) begin
            range_err = (v[63:31] != '0) && (v[63:31] != '1);
        end

        wide = 1'b0;
        if (arg < 64'(AI_1BYTE)) begin
            nfollow = 4'd0;
            info    = arg[4:0];
        end else if (arg[63:8] == '0) begin
            nfollow = 4'd1;
            info    = AI_1BYTE;
        end else if (arg[63:16] == '0) begin
            nfollow = 4'd2;
            info    = AI_2BYTE;
        end else if (arg[63:32] == '0) begin
            nfollow = 4'd4;
            info    = AI_4BYTE;
        end else begin
            nfollow = 4'd8;
            info    = AI_8BYTE;
            wide    = 1'b1;
        end
        head = {major, info};
        err  = range_err || (wide && INT64_SUPPORT == 0) || (space <= nfollow);

        unique case (t_op'(i_item.operation))
            OP_UINT, OP_SINT: ;
            OP_FLOAT: begin
                head    = HEAD_FLOAT32;
                arg     = {32'd0, v[31:0]};
                nfollow = 4'd4;
                err     = space < FLOAT_LEN;
            end
            OP_BOOL: begin
                head    = v[0] ? HEAD_TRUE : HEAD_FALSE;
                arg     = '0;
                nfollow = 4'd0;
                err     = space == 4'd0;
            end
            default: ;
        endcase

        case (nfollow)
            4'd1:    aligned = {arg[7:0], 56'd0};
            4'd2:    aligned = {arg[15:0], 48'd0};
            4'd4:    aligned = {arg[31:0], 32'd0};
            4'd8:    aligned = arg;
            default: aligned = '0;
        endcase

        if (err) begin
            o_cmd = '{head: 8'd0, arg: 64'd0, nfollow: 4'd0, err: 1'b1};
        end else begin
            o_cmd = '{head: head, arg: aligned, nfollow: nfollow, err: 1'b0};
        end
    end

endmodule

// ----- design/cse_queue.sv -----
module cse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cse_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nempty,
    output cse_pkg::t_cmd o_cmd
);
    import cse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_cmd    = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- design/cse_back.sv -----
module cse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  cse_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output cse_pkg::t_out o_data
);
    import cse_pkg::*;

    logic        r_busy;
    logic [3:0]  r_rem;
    logic [63:0] r_sh;
    logic        r_ovalid;
    t_out        r_out;

    logic        n_busy;
    logic [3:0]  n_rem;
    logic [63:0] n_sh;
    logic        n_ovalid;
    t_out        n_out;
    logic        out_free;

    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    always_comb begin
        n_busy   = r_busy;
        n_rem    = r_rem;
        n_sh     = r_sh;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        o_pop    = 1'b0;
        if (out_free) begin
            if (r_busy) begin
                n_out    = '{out_byte: r_sh[63:56], last: r_rem == 4'd1, error: 1'b0};
                n_ovalid = 1'b1;
                n_sh     = {r_sh[55:0], 8'd0};
                n_rem    = r_rem - 4'd1;
                n_busy   = r_rem != 4'd1;
            end else if (i_cmd_valid) begin
                o_pop    = 1'b1;
                n_out    = '{out_byte: i_cmd.head,
                             last:     i_cmd.nfollow == 4'd0,
                             error:    i_cmd.err};
                n_ovalid = 1'b1;
                n_sh     = i_cmd.arg;
                n_rem    = i_cmd.nfollow;
                n_busy   = i_cmd.nfollow != 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_out <= n_out;
    end

endmodule

// ----- design/cbor_scalar_encoder.sv -----
// channel | valid   | ready   | payload
// --------+---------+---------+-----------------------------------------
// input   | i_valid | o_ready | i_data (operation, value_bits, space_left)
// output  | o_valid | i_ready | o_data (out_byte, last, error)
//
// One byte per cycle while i_ready holds: an item's encoded length is 1 to 9
// bytes, which the serializer emits one per cycle into the output register.
// With the serializer idle, an accepted item goes through the queue register
// and then the output register, where its first byte becomes visible.
// A two-entry queue sits between classifier and serializer, so input keeps
// flowing while output stalls until the queue fills.
// Reset is synchronous, active low; it empties the queue and output register.
module cbor_scalar_encoder #(
    parameter int INT64_SUPPORT = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cse_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cse_pkg::t_out o_data
);
    import cse_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full;
    logic q_nempty;
    logic q_pop;

    assign o_ready = !q_full;

    cse_front #(
        .INT64_SUPPORT(INT64_SUPPORT)
    ) u_front (
        .i_item (i_data),
        .o_cmd  (front_cmd)
    );

    cse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_valid),
        .i_cmd    (front_cmd),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_nempty (q_nempty),
        .o_cmd    (q_cmd)
    );

    cse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nempty),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
